// File: sv/apsc_pkg.sv
`default_nettype none
package apsc_pkg;

    localparam int MAX_COLUMNS_DEF   = 4096;
    localparam int ALPHABET_SIZE_DEF = 26;
    localparam int COUNTER_BITS_DEF  = 32;

    localparam int THR_W  = 18;
    localparam int OUT_LW = 13;
    localparam int CV_W   = 32;
    localparam int COL_W  = 12;

    localparam logic ACT_COLUMN = 1'b0;
    localparam logic ACT_READ   = 1'b1;

    localparam logic RES_VERDICT = 1'b0;
    localparam logic RES_COUNTER = 1'b1;

    localparam logic [3:0] KIND_SUB  = 4'd0;
    localparam logic [3:0] KIND_BACK = 4'd1;
    localparam logic [3:0] KIND_MM   = 4'd2;
    localparam logic [3:0] KIND_TM   = 4'd3;
    localparam logic [3:0] KIND_GPO  = 4'd4;
    localparam logic [3:0] KIND_GPE  = 4'd5;
    localparam logic [3:0] KIND_TGP  = 4'd6;
    localparam logic [3:0] KIND_PAIR = 4'd7;
    localparam logic [3:0] KIND_LEN  = 4'd8;

    localparam logic [2:0] TR_MM  = 3'd0;
    localparam logic [2:0] TR_TM  = 3'd1;
    localparam logic [2:0] TR_GPO = 3'd2;
    localparam logic [2:0] TR_GPE = 3'd3;
    localparam logic [2:0] TR_TGP = 3'd4;

    typedef enum logic [3:0] {
        S_CLEAR,
        S_IDLE,
        S_RDRES,
        S_EVAL,
        S_CMP,
        S_TGP,
        S_WREAD,
        S_WDEC,
        S_OPRD,
        S_OPWR,
        S_FIN,
        S_DONE
    } t_state;

endpackage
`default_nettype wire

// File: sv/apsc_col_mem.sv
`default_nettype none
module apsc_col_mem #(
    parameter int DEPTH = apsc_pkg::MAX_COLUMNS_DEF
) (
    input  wire logic                       i_clk,
    input  wire logic                       i_wr_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_wr_addr,
    input  wire logic [apsc_pkg::COL_W-1:0] i_wr_data,
    input  wire logic                       i_rd_en,
    input  wire logic [$clog2(DEPTH)-1:0]   i_rd_addr,
    output logic      [apsc_pkg::COL_W-1:0] o_rd_data
);
    import apsc_pkg::*;

    logic [COL_W-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

endmodule
`default_nettype wire

// File: sv/apsc_cnt_mem.sv
`default_nettype none
module apsc_cnt_mem #(
    parameter int AW = 11,
    parameter int CB = apsc_pkg::COUNTER_BITS_DEF
) (
    input  wire logic          i_clk,
    input  wire logic          i_rst_n,
    input  wire logic          i_rd_en,
    input  wire logic [AW-1:0] i_rd_addr,
    input  wire logic          i_wr_en,
    input  wire logic [AW-1:0] i_wr_addr,
    input  wire logic [CB-1:0] i_wr_data,
    output logic      [CB-1:0] o_rd_data,
    output logic               o_busy
);
    import apsc_pkg::*;

    localparam int DEPTH = 1 << AW;

    logic [CB-1:0] r_mem [DEPTH];
    logic          r_busy;
    logic [AW-1:0] r_clr_addr;

    // clearing pass writes the pseudocount into every entry
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy     <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_busy) begin
            r_clr_addr <= r_clr_addr + 1'b1;
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_busy <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_busy) begin
            r_mem[r_clr_addr] <= CB'(1);
        end else if (i_wr_en) begin
            r_mem[i_wr_addr] <= i_wr_data;
        end
        if (i_rd_en) begin
            o_rd_data <= r_mem[i_rd_addr];
        end
    end

    assign o_busy = r_busy;

endmodule
`default_nettype wire

// File: sv/aligned_pair_substitution_counter_top.sv
// column transfer: stored while idle; read: result registered, then loaded for output once the
// output register is free; closing column: verdict after the evaluate and compare states; an
// accepted pair adds a two-gap transition update and a replay from the first both-residue
// column up to, not including, the last: two-gap columns are skipped, others add a transition
// count and up to 3 read-modify-write counter updates; synchronous active-low reset clears all
// 2^(2*ceil(log2 alphabet)+1) counter memory entries; no input transfer is taken until it ends
`default_nettype none
module aligned_pair_substitution_counter_top #(
    parameter int MAX_COLUMNS   = apsc_pkg::MAX_COLUMNS_DEF,
    parameter int ALPHABET_SIZE = apsc_pkg::ALPHABET_SIZE_DEF,
    parameter int COUNTER_BITS  = apsc_pkg::COUNTER_BITS_DEF
) (
    input  wire logic        i_clk,
    input  wire logic        i_rst_n,
    input  wire logic        i_cfg_valid,
    output logic             o_cfg_ready,
    input  wire logic [17:0] i_cfg_data,
    input  wire logic        s_axis_tvalid,
    output logic             s_axis_tready,
    // residue_a, gap_a, residue_b, gap_b, counter_kind, row_index, col_index, zero fill
    input  wire logic [31:0] s_axis_tdata,
    input  wire logic        s_axis_tlast,
    // action
    input  wire logic        s_axis_tuser,
    output logic             m_axis_tvalid,
    input  wire logic        m_axis_tready,
    // accepted, match_count, min_length, counter_value, zero fill
    output logic [63:0]      m_axis_tdata,
    // result_kind
    output logic             m_axis_tuser
);
    import apsc_pkg::*;

    localparam int CI = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
    localparam int CW = $clog2(MAX_COLUMNS + 1);
    localparam int AB = (ALPHABET_SIZE > 1) ? $clog2(ALPHABET_SIZE) : 1;
    localparam int AW = 2 * AB + 1;
    localparam int CB = COUNTER_BITS;
    localparam int PW = CW + THR_W;
    localparam int TW = CW + 1;
    localparam logic [CB-1:0] CMAX = {CB{1'b1}};

    function automatic logic [CB-1:0] sat_add(input logic [CB-1:0] v, input logic [TW-1:0] inc);
        logic [CB:0] s;
        s = {1'b0, v} + (CB+1)'(inc);
        return s[CB] ? CMAX : s[CB-1:0];
    endfunction

    t_state r_state, n_state;

    logic [THR_W-1:0] r_thr;
    logic [CW-1:0]    r_count, r_len_a, r_len_b, r_match;
    logic [CI-1:0]    r_first, r_last, r_widx;
    logic             r_seen, r_last_matched, r_gap_state;
    logic [CB-1:0]    r_tr [5];
    logic [CB-1:0]    r_pairs, r_lensum;
    logic [CW-1:0]    r_plen;
    logic [PW-1:0]    r_rhs;
    logic [CW-1:0]    r_minl;
    logic             r_acc;
    logic [3:0]       r_kind;
    logic             r_rd_ok;
    logic             r_verdict;
    logic [CV_W-1:0]  r_rdval;
    logic [2:0]       r_ops;
    logic [AW-1:0]    r_op_addr [3];
    logic [1:0]       r_op_inc0;
    logic [1:0]       r_pick;
    logic             r_ovalid, r_ouser;
    logic [63:0]      r_odata;

    // input fields
    logic [4:0] in_ra, in_rb, in_row, in_col;
    logic       in_ga, in_gb;
    logic [3:0] in_kind;
    assign in_ra   = s_axis_tdata[4:0];
    assign in_ga   = s_axis_tdata[5];
    assign in_rb   = s_axis_tdata[10:6];
    assign in_gb   = s_axis_tdata[11];
    assign in_kind = s_axis_tdata[15:12];
    assign in_row  = s_axis_tdata[20:16];
    assign in_col  = s_axis_tdata[25:21];

    logic in_xfer;
    assign in_xfer = s_axis_tvalid && s_axis_tready;

    // column store
    logic             col_wr, col_rd;
    logic [COL_W-1:0] col_q;
    assign col_wr = in_xfer && (s_axis_tuser == ACT_COLUMN) && (r_count < CW'(MAX_COLUMNS));
    assign col_rd = (r_state == S_WREAD);

    apsc_col_mem #(.DEPTH(MAX_COLUMNS)) u_col (
        .i_clk    (i_clk),
        .i_wr_en  (col_wr),
        .i_wr_addr(r_count[CI-1:0]),
        .i_wr_data(s_axis_tdata[COL_W-1:0]),
        .i_rd_en  (col_rd),
        .i_rd_addr(r_widx),
        .o_rd_data(col_q)
    );

    // counter memory
    logic          cm_rd, cm_wr, cm_busy;
    logic [AW-1:0] cm_rd_addr;
    logic [CB-1:0] cm_q, cm_wdata;
    logic [1:0]    pick;
    logic [1:0]    op_inc;

    always_comb begin
        pick = r_ops[0] ? 2'd0 : (r_ops[1] ? 2'd1 : 2'd2);
        op_inc = (r_pick == 2'd0) ? r_op_inc0 : 2'd1;
        cm_rd = 1'b0;
        cm_rd_addr = r_op_addr[pick];
        if (r_state == S_IDLE) begin
            cm_rd = in_xfer && (s_axis_tuser == ACT_READ);
            cm_rd_addr = (in_kind == KIND_SUB) ? {1'b0, in_row[AB-1:0], in_col[AB-1:0]}
                                               : {1'b1, in_row[AB-1:0], {AB{1'b0}}};
        end else if (r_state == S_OPRD) begin
            cm_rd = 1'b1;
        end
        cm_wr = (r_state == S_OPWR);
        cm_wdata = sat_add(cm_q, TW'(op_inc));
    end

    apsc_cnt_mem #(.AW(AW), .CB(CB)) u_cnt (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_rd_en  (cm_rd),
        .i_rd_addr(cm_rd_addr),
        .i_wr_en  (cm_wr),
        .i_wr_addr(r_op_addr[r_pick]),
        .i_wr_data(cm_wdata),
        .o_rd_data(cm_q),
        .o_busy   (cm_busy)
    );

    // decode of a replayed column
    logic [4:0] w_ra, w_rb;
    logic       w_ga, w_gb, w_ra_ok, w_rb_ok;
    assign w_ra = col_q[4:0];
    assign w_ga = col_q[5];
    assign w_rb = col_q[10:6];
    assign w_gb = col_q[11];
    assign w_ra_ok = {1'b0, w_ra} < 6'(ALPHABET_SIZE);
    assign w_rb_ok = {1'b0, w_rb} < 6'(ALPHABET_SIZE);

    // transition register access, one index at a time
    logic [2:0]    tr_sel;
    logic [CB-1:0] tr_q;
    always_comb begin
        unique case (r_state)
            S_IDLE:  tr_sel = 3'(in_kind - KIND_MM);
            S_RDRES: tr_sel = 3'(r_kind - KIND_MM);
            S_TGP:   tr_sel = TR_TGP;
            default: tr_sel = r_gap_state ? ((w_ga || w_gb) ? TR_GPE : TR_TM)
                                          : ((w_ga || w_gb) ? TR_GPO : TR_MM);
        endcase
        tr_q = (tr_sel < 3'd5) ? r_tr[tr_sel] : '0;
    end

    logic [CW-1:0]  minl;
    logic [TW-1:0]  tg;
    logic [PW-1:0]  lhs;
    logic [CB-1:0]  rd_val;
    assign minl = (r_len_a < r_len_b) ? r_len_a : r_len_b;
    assign tg = r_seen ? (TW'(r_first) + TW'(1) + TW'(r_count) - TW'(r_last))
                       : {r_count, 1'b0};
    assign lhs = PW'({TW'(r_match) + TW'(1), 16'b0});

    always_comb begin
        case (r_kind)
            KIND_SUB, KIND_BACK: rd_val = r_rd_ok ? cm_q : '0;
            KIND_PAIR:           rd_val = r_pairs;
            KIND_LEN:            rd_val = r_lensum;
            default:             rd_val = r_rd_ok ? tr_q : '0;
        endcase
    end

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            S_CLEAR: if (!cm_busy) n_state = S_IDLE;
            S_IDLE: begin
                if (in_xfer) begin
                    if (s_axis_tuser == ACT_READ) n_state = S_RDRES;
                    else if (s_axis_tlast) n_state = S_EVAL;
                end
            end
            S_RDRES: n_state = S_DONE;
            S_EVAL:  n_state = S_CMP;
            S_CMP:   n_state = ((r_minl == '0) || (lhs > r_rhs)) ? S_TGP : S_DONE;
            S_TGP:   n_state = S_WREAD;
            S_WREAD: n_state = (r_seen && (r_widx < r_last)) ? S_WDEC : S_FIN;
            S_WDEC:  n_state = (w_ga && w_gb) ? S_WREAD : S_OPRD;
            S_OPRD:  n_state = (r_ops == 3'b000) ? S_WREAD : S_OPWR;
            S_OPWR:  n_state = S_OPRD;
            S_FIN:   n_state = S_DONE;
            S_DONE:  if (!r_ovalid || m_axis_tready) n_state = S_IDLE;
            default: n_state = S_CLEAR;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLEAR;
        end else begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_thr <= '0;
            r_count <= '0;
            r_len_a <= '0;
            r_len_b <= '0;
            r_match <= '0;
            r_first <= '0;
            r_last <= '0;
            r_seen <= 1'b0;
            r_last_matched <= 1'b0;
            r_gap_state <= 1'b0;
            for (int k = 0; k < 5; k++) r_tr[k] <= CB'(1);
            r_pairs <= '0;
            r_lensum <= '0;
            r_ops <= '0;
            r_ovalid <= 1'b0;
            r_verdict <= 1'b0;
        end else begin
            if (i_cfg_valid) r_thr <= i_cfg_data;
            if (m_axis_tready && r_state != S_DONE) r_ovalid <= 1'b0;
            unique case (r_state)
                S_IDLE: begin
                    if (in_xfer && s_axis_tuser == ACT_READ) begin
                        r_kind <= in_kind;
                        r_verdict <= 1'b0;
                        r_rd_ok <= (in_kind == KIND_SUB) ?
                            ({1'b0, in_row} < 6'(ALPHABET_SIZE) &&
                             {1'b0, in_col} < 6'(ALPHABET_SIZE)) :
                            (in_kind == KIND_BACK) ? ({1'b0, in_row} < 6'(ALPHABET_SIZE)) :
                            (in_kind >= KIND_MM && in_kind <= KIND_TGP);
                    end else if (col_wr) begin
                        if (!in_ga) r_len_a <= r_len_a + 1'b1;
                        if (!in_gb) r_len_b <= r_len_b + 1'b1;
                        if (!in_ga && !in_gb) begin
                            if (r_seen) begin
                                if (r_last_matched) r_match <= r_match + 1'b1;
                            end else begin
                                r_first <= r_count[CI-1:0];
                                r_seen <= 1'b1;
                            end
                            r_last <= r_count[CI-1:0];
                            r_last_matched <= (in_ra == in_rb);
                        end
                        r_count <= r_count + 1'b1;
                    end
                end
                S_EVAL: begin
                    r_minl <= minl;
                    r_rhs <= PW'(r_thr) * PW'(minl);
                end
                S_CMP: begin
                    r_acc <= (r_minl == '0) || (lhs > r_rhs);
                    r_widx <= r_first;
                    r_plen <= '0;
                    r_gap_state <= 1'b0;
                end
                S_TGP: r_tr[tr_sel] <= sat_add(tr_q, tg);
                S_WDEC: begin
                    if (!(w_ga && w_gb)) begin
                        r_tr[tr_sel] <= sat_add(tr_q, TW'(1));
                        r_plen <= r_plen + 1'b1;
                        r_gap_state <= w_ga || w_gb;
                        r_op_addr[0] <= (w_ra >= w_rb) ?
                            {1'b0, w_ra[AB-1:0], w_rb[AB-1:0]} :
                            {1'b0, w_rb[AB-1:0], w_ra[AB-1:0]};
                        r_op_inc0 <= (w_ra == w_rb) ? 2'd2 : 2'd1;
                        r_op_addr[1] <= {1'b1, w_ra[AB-1:0], {AB{1'b0}}};
                        r_op_addr[2] <= {1'b1, w_rb[AB-1:0], {AB{1'b0}}};
                        if (!w_ga && !w_gb) begin
                            r_ops <= {w_rb_ok, w_ra_ok, w_ra_ok && w_rb_ok};
                        end else if (w_ga) begin
                            r_ops <= {w_rb_ok, 2'b00};
                        end else begin
                            r_ops <= {1'b0, w_ra_ok, 1'b0};
                        end
                    end else begin
                        r_widx <= r_widx + 1'b1;
                    end
                end
                S_OPRD: begin
                    r_pick <= pick;
                    if (r_ops == 3'b000) r_widx <= r_widx + 1'b1;
                end
                S_OPWR: r_ops[r_pick] <= 1'b0;
                S_FIN: begin
                    r_pairs <= sat_add(r_pairs, TW'(1));
                    r_lensum <= sat_add(r_lensum, TW'(r_plen));
                end
                S_DONE: begin
                    if (!r_ovalid || m_axis_tready) begin
                        r_ovalid <= 1'b1;
                        if (r_verdict) begin
                            r_ouser <= RES_VERDICT;
                            r_odata <= {37'b0, OUT_LW'(r_minl), OUT_LW'(r_match), r_acc};
                            r_count <= '0;
                            r_len_a <= '0;
                            r_len_b <= '0;
                            r_match <= '0;
                            r_first <= '0;
                            r_last <= '0;
                            r_seen <= 1'b0;
                            r_last_matched <= 1'b0;
                            r_gap_state <= 1'b0;
                        end else begin
                            r_ouser <= RES_COUNTER;
                            r_odata <= {5'b0, r_rdval, 27'b0};
                        end
                    end
                end
                default: ;
            endcase
            // verdict flag holds until the next read transfer is accepted
            if (r_state == S_EVAL) r_verdict <= 1'b1;
            if (r_state == S_RDRES) r_rdval <= CV_W'(rd_val);
        end
    end

    assign o_cfg_ready   = 1'b1;
    assign s_axis_tready = (r_state == S_IDLE);
    assign m_axis_tvalid = r_ovalid;
    assign m_axis_tdata  = r_odata;
    assign m_axis_tuser  = r_ouser;

endmodule
`default_nettype wire
